@@ hw/rtl/pnav_pkg.sv @@
// ----------------------------------------------------------------------------
// pnav_pkg
// Shared constants, register indexes, status codes and pipeline side-band
// types for the proportional navigation guidance block.
// ----------------------------------------------------------------------------
package pnav_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int GAIN_FRAC  = 16;
    localparam int RATE_FRAC  = 24;
    localparam int PROD_SHIFT = GAIN_FRAC + RATE_FRAC;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam int GAIN_W   = 24;
    localparam int ACCEL_W  = 24;
    localparam int RANGE_W  = 31;
    localparam int RANGE_SQ_W = 2 * RANGE_W;

    // Long divider and square root geometry.
    localparam int DIV_NW   = 64;
    localparam int DIV_DW   = 36;
    localparam int SQ_RW    = 64;
    localparam int SQ_STEPS = SQ_RW / 2;

    localparam logic [63:0] CLOSE_MIN  = 64'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [63:0] RATE_EPS   = 64'((64'd1 << RATE_FRAC) / 64'd1000);
    localparam logic [63:0] FIVE_SEC   = 64'(64'd5 << GAIN_FRAC);
    localparam logic [31:0] BIAS_RANGE = 32'(32'd5 << FRAC_BITS);

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_BASE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SLOPE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENGAGE_RANGE = 4'd3;

    localparam logic [STATUS_W-1:0] ST_GUIDED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOCLOSE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BIAS    = 2'd3;

    typedef struct packed {
        logic [GAIN_W-1:0]     gain_base;
        logic [GAIN_W-1:0]     gain_slope;
        logic [ACCEL_W-2:0]    half_accel;
        logic [RANGE_W-1:0]    erange;
        logic [RANGE_SQ_W-1:0] erange_sq;
    } cfg_t;

    // Side-band carried through the square root.
    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] rvx;
        logic signed [31:0] rvy;
        logic               oor;
    } sq_sb_t;

    // Side-band carried through the closing speed and cross-rate dividers.
    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic [31:0]        d;
        logic               dot_pos;
        logic               cr_neg;
        logic               oor;
    } dva_sb_t;

    // Side-band carried through the rate and time-to-go dividers.
    // The closing speed can reach 2^32 on a very short line of sight.
    typedef struct packed {
        logic signed [31:0]  dx;
        logic signed [31:0]  dy;
        logic [31:0]         d;
        logic [32:0]         c;
        logic                neg;
        logic [STATUS_W-1:0] status;
    } dvb_sb_t;

    // Side-band carried through the command dividers.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                nx_neg;
        logic                ny_neg;
    } dvc_sb_t;

    localparam int TAG_SQ = $bits(sq_sb_t);
    localparam int TAG_A  = $bits(dva_sb_t);
    localparam int TAG_B  = $bits(dvb_sb_t);
    localparam int TAG_C  = $bits(dvc_sb_t);
    localparam int TAG_M1 = (TAG_SQ > TAG_A) ? TAG_SQ : TAG_A;
    localparam int TAG_M2 = (TAG_B > TAG_C) ? TAG_B : TAG_C;
    localparam int TAG_W  = (TAG_M1 > TAG_M2) ? TAG_M1 : TAG_M2;

endpackage

@@ hw/rtl/pnav_cfg.sv @@
// ----------------------------------------------------------------------------
// pnav_cfg
// Configuration register file with the derived squared engagement range.
// ----------------------------------------------------------------------------
module pnav_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [pnav_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pnav_pkg::CFG_DATA_W-1:0] cfg_data,
    output pnav_pkg::cfg_t                 cfg
);
    import pnav_pkg::*;

    logic [GAIN_W-1:0]     base_reg;
    logic [GAIN_W-1:0]     slope_reg;
    logic [ACCEL_W-1:0]    accel_reg;
    logic [RANGE_W-1:0]    erange_reg;
    logic [RANGE_SQ_W-1:0] erange_sq_reg;
    logic [RANGE_SQ_W-1:0] erange_sq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= 24'd196608;
            slope_reg  <= 24'd32768;
            accel_reg  <= 24'd1310720;
            erange_reg <= 31'd3276800;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_BASE:    base_reg   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_SLOPE:   slope_reg  <= cfg_data[GAIN_W-1:0];
                REG_ACCEL_LIMIT:  accel_reg  <= cfg_data[ACCEL_W-1:0];
                REG_ENGAGE_RANGE: erange_reg <= cfg_data[RANGE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign erange_sq_next = erange_reg * erange_reg;

    // The range square is registered; the user must only write while idle, which the block does not enforce.
    always_ff @(posedge clk)
    begin
        erange_sq_reg <= erange_sq_next;
    end

    always_comb
    begin
        cfg.gain_base  = base_reg;
        cfg.gain_slope = slope_reg;
        cfg.half_accel = accel_reg[ACCEL_W-1:1];
        cfg.erange     = erange_reg;
        cfg.erange_sq  = erange_sq_reg;
    end

endmodule

@@ hw/rtl/pnav_sqrt.sv @@
// ----------------------------------------------------------------------------
// pnav_sqrt
// Pipelined integer square root, one result bit per stage, with side-band.
// ----------------------------------------------------------------------------
module pnav_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [pnav_pkg::SQ_RW-1:0]    rad,
    input  logic [pnav_pkg::TAG_W-1:0]    tag_in,
    output logic                         out_valid,
    output logic [pnav_pkg::SQ_STEPS-1:0] root,
    output logic [pnav_pkg::TAG_W-1:0]    tag_out
);
    import pnav_pkg::*;

    localparam int REM_W = SQ_STEPS + 2;

    logic                valid_reg [0:SQ_STEPS];
    logic [SQ_RW-1:0]    rad_reg   [0:SQ_STEPS];
    logic [REM_W-1:0]    rem_reg   [0:SQ_STEPS];
    logic [SQ_STEPS-1:0] root_reg  [0:SQ_STEPS];
    logic [TAG_W-1:0]    tag_reg   [0:SQ_STEPS];

    logic [REM_W+1:0]    trial     [0:SQ_STEPS-1];
    logic [REM_W+1:0]    probe     [0:SQ_STEPS-1];
    logic [REM_W-1:0]    rem_next  [0:SQ_STEPS-1];
    logic [SQ_STEPS-1:0] root_next [0:SQ_STEPS-1];

    always_comb
    begin
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            trial[i] = {rem_reg[i], rad_reg[i][SQ_RW-1:SQ_RW-2]};
            probe[i] = (REM_W+2)'({root_reg[i], 2'b01});
            if (trial[i] >= probe[i])
            begin
                rem_next[i]  = REM_W'(trial[i] - probe[i]);
                root_next[i] = {root_reg[i][SQ_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = trial[i][REM_W-1:0];
                root_next[i] = {root_reg[i][SQ_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SQ_STEPS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg[0]  <= rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            tag_reg[0]  <= tag_in;
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                rad_reg[i+1]  <= {rad_reg[i][SQ_RW-3:0], 2'b00};
                rem_reg[i+1]  <= rem_next[i];
                root_reg[i+1] <= root_next[i];
                tag_reg[i+1]  <= tag_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[SQ_STEPS];
    assign root      = root_reg[SQ_STEPS];
    assign tag_out   = tag_reg[SQ_STEPS];

endmodule

@@ hw/rtl/pnav_div.sv @@
// ----------------------------------------------------------------------------
// pnav_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with
// side-band. Division by zero yields all ones.
// ----------------------------------------------------------------------------
module pnav_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [pnav_pkg::DIV_NW-1:0] num,
    input  logic [pnav_pkg::DIV_DW-1:0] den,
    input  logic [pnav_pkg::TAG_W-1:0]  tag_in,
    output logic                       out_valid,
    output logic [pnav_pkg::DIV_NW-1:0] quo,
    output logic [pnav_pkg::TAG_W-1:0]  tag_out
);
    import pnav_pkg::*;

    logic              valid_reg [0:DIV_NW];
    logic [DIV_NW-1:0] acc_reg   [0:DIV_NW];
    logic [DIV_DW-1:0] rem_reg   [0:DIV_NW];
    logic [DIV_DW-1:0] den_reg   [0:DIV_NW];
    logic [TAG_W-1:0]  tag_reg   [0:DIV_NW];

    logic [DIV_DW:0]   trial     [0:DIV_NW-1];
    logic [DIV_DW-1:0] rem_next  [0:DIV_NW-1];
    logic [DIV_NW-1:0] acc_next  [0:DIV_NW-1];

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb
    begin
        for (int i = 0; i < DIV_NW; i++)
        begin
            trial[i] = {rem_reg[i], acc_reg[i][DIV_NW-1]};
            if (trial[i] >= {1'b0, den_reg[i]})
            begin
                rem_next[i] = DIV_DW'(trial[i] - {1'b0, den_reg[i]});
                acc_next[i] = {acc_reg[i][DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[i][DIV_DW-1:0];
                acc_next[i] = {acc_reg[i][DIV_NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_NW; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 0; i < DIV_NW; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg[0] <= num;
            rem_reg[0] <= '0;
            den_reg[0] <= den;
            tag_reg[0] <= tag_in;
            for (int i = 0; i < DIV_NW; i++)
            begin
                acc_reg[i+1] <= acc_next[i];
                rem_reg[i+1] <= rem_next[i];
                den_reg[i+1] <= den_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[DIV_NW];
    assign quo       = acc_reg[DIV_NW];
    assign tag_out   = tag_reg[DIV_NW];

endmodule

@@ hw/rtl/proportional_navigation_guidance_top.sv @@
// The block takes one request per clock cycle unless stalled, and returns one
// guidance command per request, in order. The datapath runs in series: a
// 32-stage square root for the range and three 64-stage long dividers
// (closing speed and cross rate, then line-of-sight rate and time-to-go, then
// the two command components), plus the multiplier stages between them. While
// a result waits on the output and out_ready is low, the whole pipeline
// freezes and no request is accepted; while no result waits, the pipeline keeps
// moving whatever out_ready does. Configuration writes are always accepted and
// must only be issued while the block is idle.
// ----------------------------------------------------------------------------
// proportional_navigation_guidance_top
// Two-dimensional proportional navigation guidance, fully pipelined.
// ----------------------------------------------------------------------------
module proportional_navigation_guidance_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [pnav_pkg::WORD_W-1:0] tgt_px,
    input  logic signed [pnav_pkg::WORD_W-1:0] tgt_py,
    input  logic signed [pnav_pkg::WORD_W-1:0] own_px,
    input  logic signed [pnav_pkg::WORD_W-1:0] own_py,
    input  logic signed [pnav_pkg::WORD_W-1:0] tgt_vx,
    input  logic signed [pnav_pkg::WORD_W-1:0] tgt_vy,
    input  logic signed [pnav_pkg::WORD_W-1:0] own_vx,
    input  logic signed [pnav_pkg::WORD_W-1:0] own_vy,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [pnav_pkg::WORD_W-1:0] cmd_ax,
    output logic signed [pnav_pkg::WORD_W-1:0] cmd_ay,
    output logic [pnav_pkg::STATUS_W-1:0]      guide_status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pnav_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pnav_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pnav_pkg::*;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31])
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -34'sh0_8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    cfg_t cfg;
    logic adv;

    logic out_valid_reg;
    logic signed [31:0] cmd_ax_reg, cmd_ay_reg;
    logic [STATUS_W-1:0] status_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    pnav_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ---------------- Stage 1: differences ----------------
    logic v1_reg;
    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [31:0] rvx1_reg, rvy1_reg;
    logic signed [32:0] dx1_next, dy1_next;
    logic signed [31:0] rvx1_next, rvy1_next;

    assign dx1_next  = 33'(tgt_px) - 33'(own_px);
    assign dy1_next  = 33'(tgt_py) - 33'(own_py);
    assign rvx1_next = sat33(33'(tgt_vx) - 33'(own_vx));
    assign rvy1_next = sat33(33'(tgt_vy) - 33'(own_vy));

    // ---------------- Stage 2: window box and squares ----------------
    logic v2_reg, box2_reg;
    logic signed [31:0] dx2_reg, dy2_reg, rvx2_reg, rvy2_reg;
    logic [63:0] sqx2_reg, sqy2_reg;
    logic signed [32:0] erange_s;
    logic signed [31:0] dx1_w, dy1_w;
    logic box2_next;
    logic signed [63:0] sqx2_next, sqy2_next;

    assign erange_s  = $signed({2'b00, cfg.erange});
    assign box2_next = (dx1_reg > erange_s) || (dx1_reg < -erange_s)
                    || (dy1_reg > erange_s) || (dy1_reg < -erange_s);
    assign dx1_w     = $signed(dx1_reg[31:0]);
    assign dy1_w     = $signed(dy1_reg[31:0]);
    assign sqx2_next = dx1_w * dx1_w;
    assign sqy2_next = dy1_w * dy1_w;

    // ---------------- Stage 3: sum into the square root ----------------
    logic [63:0] sum3_next;
    logic oor3_next;
    sq_sb_t sq_in, sq_o;
    logic sq_valid;
    logic [SQ_STEPS-1:0] sq_root;
    logic [TAG_W-1:0] sq_tag;

    assign sum3_next = sqx2_reg + sqy2_reg;
    assign oor3_next = box2_reg || (sum3_next == 64'd0)
                    || (sum3_next > 64'(cfg.erange_sq));

    always_comb
    begin
        sq_in.dx  = dx2_reg;
        sq_in.dy  = dy2_reg;
        sq_in.rvx = rvx2_reg;
        sq_in.rvy = rvy2_reg;
        sq_in.oor = oor3_next;
    end

    pnav_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v2_reg),
        .rad       (sum3_next),
        .tag_in    (TAG_W'(sq_in)),
        .out_valid (sq_valid),
        .root      (sq_root),
        .tag_out   (sq_tag)
    );

    assign sq_o = sq_sb_t'(sq_tag[TAG_SQ-1:0]);

    // ---------------- Stage 4: velocity products ----------------
    logic v4_reg, oor4_reg;
    logic signed [31:0] dx4_reg, dy4_reg;
    logic [31:0] d4_reg;
    logic signed [63:0] pxx4_reg, pyy4_reg, pxy4_reg, pyx4_reg;

    // ---------------- Stage 5: dot and cross sums ----------------
    logic v5_reg, oor5_reg;
    logic signed [31:0] dx5_reg, dy5_reg;
    logic [31:0] d5_reg;
    logic signed [64:0] dot5_reg, cr5_reg;
    logic signed [64:0] dot5_neg, cr5_neg;
    logic [63:0] dot_mag, cr_mag;
    dva_sb_t dva_in, dva_o;

    assign dot5_neg = -dot5_reg;
    assign cr5_neg  = -cr5_reg;
    assign dot_mag  = dot5_reg[64] ? dot5_neg[63:0] : dot5_reg[63:0];
    assign cr_mag   = cr5_reg[64]  ? cr5_neg[63:0]  : cr5_reg[63:0];

    always_comb
    begin
        dva_in.dx      = dx5_reg;
        dva_in.dy      = dy5_reg;
        dva_in.d       = d5_reg;
        dva_in.dot_pos = ~dot5_reg[64];
        dva_in.cr_neg  = cr5_reg[64];
        dva_in.oor     = oor5_reg;
    end

    logic va_valid;
    logic [DIV_NW-1:0] qc, qp;
    logic [TAG_W-1:0] va_tag;

    pnav_div u_div_close (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v5_reg),
        .num       (dot_mag),
        .den       (DIV_DW'(d5_reg)),
        .tag_in    (TAG_W'(dva_in)),
        .out_valid (va_valid),
        .quo       (qc),
        .tag_out   (va_tag)
    );

    pnav_div u_div_perp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v5_reg),
        .num       (cr_mag),
        .den       (DIV_DW'(d5_reg)),
        .tag_in    ('0),
        .out_valid (),
        .quo       (qp),
        .tag_out   ()
    );

    assign dva_o = dva_sb_t'(va_tag[TAG_A-1:0]);

    // ---------------- Rate and time-to-go dividers ----------------
    logic ncl_a;
    dvb_sb_t dvb_in, dvb_o;
    logic vb_valid;
    logic [DIV_NW-1:0] qr, qt;
    logic [TAG_W-1:0] vb_tag;

    // A positive dot product means the range is opening: never closing.
    assign ncl_a = dva_o.dot_pos || (qc <= CLOSE_MIN);

    always_comb
    begin
        dvb_in.dx  = dva_o.dx;
        dvb_in.dy  = dva_o.dy;
        dvb_in.d   = dva_o.d;
        dvb_in.c   = qc[32:0];
        dvb_in.neg = dva_o.cr_neg;
        if (dva_o.oor)
            dvb_in.status = ST_RANGE;
        else if (ncl_a)
            dvb_in.status = ST_NOCLOSE;
        else
            dvb_in.status = ST_GUIDED;
    end

    pnav_div u_div_rate (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (va_valid),
        .num       ({qp[DIV_NW-RATE_FRAC-1:0], {RATE_FRAC{1'b0}}}),
        .den       (DIV_DW'(dva_o.d)),
        .tag_in    (TAG_W'(dvb_in)),
        .out_valid (vb_valid),
        .quo       (qr),
        .tag_out   (vb_tag)
    );

    pnav_div u_div_tgo (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (va_valid),
        .num       (DIV_NW'({dva_o.d, {GAIN_FRAC{1'b0}}})),
        .den       (qc[DIV_DW-1:0]),
        .tag_in    ('0),
        .out_valid (),
        .quo       (qt),
        .tag_out   ()
    );

    assign dvb_o = dvb_sb_t'(vb_tag[TAG_B-1:0]);

    // ---------------- Stages 7 to 14: gain and magnitude ----------------
    logic bias7_next;
    logic [18:0] diff7_next;
    logic [63:0] five_minus_t;

    assign bias7_next   = (qr < RATE_EPS) && (dvb_o.d > BIAS_RANGE);
    assign five_minus_t = FIVE_SEC - qt;
    assign diff7_next   = (qt < FIVE_SEC) ? five_minus_t[18:0] : 19'd0;

    logic v7_reg, bias7_reg;
    dvb_sb_t sb7_reg;
    logic [56:0] r7_reg;
    logic [18:0] diff7_reg;

    logic v8_reg, bias8_reg;
    dvb_sb_t sb8_reg;
    logic [56:0] r8_reg;
    logic [42:0] sprod8_reg;

    logic v9_reg, bias9_reg;
    dvb_sb_t sb9_reg;
    logic [56:0] r9_reg;
    logic [27:0] n9_reg;

    logic v10_reg, bias10_reg;
    dvb_sb_t sb10_reg;
    logic [56:0] r10_reg;
    logic [59:0] nc10_reg;

    logic v11_reg, bias11_reg;
    dvb_sb_t sb11_reg;
    logic [63:0] p00_11_reg;
    logic [56:0] p01_11_reg;
    logic [59:0] p10_11_reg;
    logic [52:0] p11_11_reg;

    logic v12_reg, bias12_reg;
    dvb_sb_t sb12_reg;
    logic [63:0] p00_12_reg;
    logic [52:0] p11_12_reg;
    logic [60:0] mid12_reg;

    logic v13_reg, bias13_reg;
    dvb_sb_t sb13_reg;
    logic [116:0] full13_reg;

    logic v14_reg;
    logic signed [31:0] dx14_reg, dy14_reg;
    logic [31:0] d14_reg;
    logic signed [32:0] a14_reg;
    logic [STATUS_W-1:0] st14_reg;

    logic [76:0] sh13;
    logic [31:0] am13;
    logic signed [32:0] am13_s, a14_next;
    logic [STATUS_W-1:0] st14_next;

    assign sh13   = full13_reg[116:PROD_SHIFT];
    assign am13   = ((|sh13[76:32]) || (sh13[31:0] > 32'h8000_0000))
                  ? 32'h8000_0000 : sh13[31:0];
    assign am13_s = $signed({1'b0, am13});

    always_comb
    begin
        if (bias13_reg)
            a14_next = $signed(33'(cfg.half_accel));
        else if (sb13_reg.neg)
            a14_next = -am13_s;
        else
            a14_next = am13_s;
        if (sb13_reg.status != ST_GUIDED)
            st14_next = sb13_reg.status;
        else if (bias13_reg)
            st14_next = ST_BIAS;
        else
            st14_next = ST_GUIDED;
    end

    // ---------------- Stage 15: command products ----------------
    logic v15_reg;
    logic [31:0] d15_reg;
    logic [STATUS_W-1:0] st15_reg;
    logic signed [64:0] px15_reg, py15_reg;
    logic signed [64:0] px15_neg, py15_neg;
    logic [63:0] nx_mag, ny_mag;
    dvc_sb_t dvc_in, dvc_o;

    assign px15_neg = -px15_reg;
    assign py15_neg = -py15_reg;
    assign nx_mag   = px15_reg[64] ? px15_neg[63:0] : px15_reg[63:0];
    assign ny_mag   = py15_reg[64] ? py15_neg[63:0] : py15_reg[63:0];

    always_comb
    begin
        dvc_in.status = st15_reg;
        // The x command is the negated a*dy quotient.
        dvc_in.nx_neg = ~px15_reg[64];
        dvc_in.ny_neg = py15_reg[64];
    end

    logic vc_valid;
    logic [DIV_NW-1:0] qx, qy;
    logic [TAG_W-1:0] vc_tag;

    pnav_div u_div_cmdx (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v15_reg),
        .num       (nx_mag),
        .den       (DIV_DW'(d15_reg)),
        .tag_in    (TAG_W'(dvc_in)),
        .out_valid (vc_valid),
        .quo       (qx),
        .tag_out   (vc_tag)
    );

    pnav_div u_div_cmdy (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v15_reg),
        .num       (ny_mag),
        .den       (DIV_DW'(d15_reg)),
        .tag_in    ('0),
        .out_valid (),
        .quo       (qy),
        .tag_out   ()
    );

    assign dvc_o = dvc_sb_t'(vc_tag[TAG_C-1:0]);

    // ---------------- Output stage ----------------
    logic signed [33:0] qx_s, qy_s, ax_v, ay_v;
    logic signed [31:0] cmd_ax_next, cmd_ay_next;
    logic zero_cmd;

    assign qx_s     = $signed({1'b0, qx[32:0]});
    assign qy_s     = $signed({1'b0, qy[32:0]});
    assign ax_v     = dvc_o.nx_neg ? -qx_s : qx_s;
    assign ay_v     = dvc_o.ny_neg ? -qy_s : qy_s;
    assign zero_cmd = (dvc_o.status == ST_RANGE) || (dvc_o.status == ST_NOCLOSE);
    assign cmd_ax_next = zero_cmd ? 32'sd0 : sat34(ax_v);
    assign cmd_ay_next = zero_cmd ? 32'sd0 : sat34(ay_v);

    // ---------------- Valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            v12_reg       <= 1'b0;
            v13_reg       <= 1'b0;
            v14_reg       <= 1'b0;
            v15_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v4_reg        <= sq_valid;
            v5_reg        <= v4_reg;
            v7_reg        <= vb_valid;
            v8_reg        <= v7_reg;
            v9_reg        <= v8_reg;
            v10_reg       <= v9_reg;
            v11_reg       <= v10_reg;
            v12_reg       <= v11_reg;
            v13_reg       <= v12_reg;
            v14_reg       <= v13_reg;
            v15_reg       <= v14_reg;
            out_valid_reg <= vc_valid;
        end
    end

    // ---------------- Payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg  <= dx1_next;
            dy1_reg  <= dy1_next;
            rvx1_reg <= rvx1_next;
            rvy1_reg <= rvy1_next;

            box2_reg <= box2_next;
            dx2_reg  <= dx1_w;
            dy2_reg  <= dy1_w;
            rvx2_reg <= rvx1_reg;
            rvy2_reg <= rvy1_reg;
            sqx2_reg <= sqx2_next;
            sqy2_reg <= sqy2_next;

            oor4_reg <= sq_o.oor;
            dx4_reg  <= sq_o.dx;
            dy4_reg  <= sq_o.dy;
            d4_reg   <= sq_root;
            pxx4_reg <= sq_o.rvx * sq_o.dx;
            pyy4_reg <= sq_o.rvy * sq_o.dy;
            pxy4_reg <= sq_o.dx * sq_o.rvy;
            pyx4_reg <= sq_o.dy * sq_o.rvx;

            oor5_reg <= oor4_reg;
            dx5_reg  <= dx4_reg;
            dy5_reg  <= dy4_reg;
            d5_reg   <= d4_reg;
            dot5_reg <= 65'(pxx4_reg) + 65'(pyy4_reg);
            cr5_reg  <= 65'(pxy4_reg) - 65'(pyx4_reg);

            sb7_reg   <= dvb_o;
            bias7_reg <= bias7_next;
            r7_reg    <= qr[56:0];
            diff7_reg <= diff7_next;

            sb8_reg    <= sb7_reg;
            bias8_reg  <= bias7_reg;
            r8_reg     <= r7_reg;
            sprod8_reg <= cfg.gain_slope * diff7_reg;

            sb9_reg   <= sb8_reg;
            bias9_reg <= bias8_reg;
            r9_reg    <= r8_reg;
            n9_reg    <= 28'(cfg.gain_base) + 28'(sprod8_reg[42:GAIN_FRAC]);

            sb10_reg   <= sb9_reg;
            bias10_reg <= bias9_reg;
            r10_reg    <= r9_reg;
            nc10_reg   <= n9_reg * sb9_reg.c;

            sb11_reg   <= sb10_reg;
            bias11_reg <= bias10_reg;
            p00_11_reg <= nc10_reg[31:0]  * r10_reg[31:0];
            p01_11_reg <= nc10_reg[31:0]  * r10_reg[56:32];
            p10_11_reg <= nc10_reg[59:32] * r10_reg[31:0];
            p11_11_reg <= nc10_reg[59:32] * r10_reg[56:32];

            sb12_reg   <= sb11_reg;
            bias12_reg <= bias11_reg;
            p00_12_reg <= p00_11_reg;
            p11_12_reg <= p11_11_reg;
            mid12_reg  <= 61'(p01_11_reg) + 61'(p10_11_reg);

            sb13_reg   <= sb12_reg;
            bias13_reg <= bias12_reg;
            full13_reg <= {p11_12_reg, p00_12_reg} + (117'(mid12_reg) << 32);

            dx14_reg <= sb13_reg.dx;
            dy14_reg <= sb13_reg.dy;
            d14_reg  <= sb13_reg.d;
            a14_reg  <= a14_next;
            st14_reg <= st14_next;

            d15_reg  <= d14_reg;
            st15_reg <= st14_reg;
            px15_reg <= a14_reg * dy14_reg;
            py15_reg <= a14_reg * dx14_reg;

            cmd_ax_reg <= cmd_ax_next;
            cmd_ay_reg <= cmd_ay_next;
            status_reg <= dvc_o.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cmd_ax       = cmd_ax_reg;
    assign cmd_ay       = cmd_ay_reg;
    assign guide_status = status_reg;

endmodule
